>>> rtl/omd_pkg.sv
// ----------------------------------------------------------------------------
// omd_pkg
// Shared types, constants and register codes for the obstacle margin
// dilation block.
// ----------------------------------------------------------------------------
package omd_pkg;

  // Frame and window limits
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_MARGIN  = 7;
  localparam int QUIET_SAT   = 2 * MAX_MARGIN + 1;
  localparam int DELAY_DEPTH = MAX_MARGIN * (MAX_WIDTH + MAX_MARGIN) + MAX_MARGIN;

  // Field and internal widths
  localparam int PIX_W    = 8;
  localparam int DIM_W    = 11;
  localparam int MARGIN_W = 3;
  localparam int QUIET_W  = $clog2(QUIET_SAT + 1);
  localparam int COL_AW   = $clog2(MAX_WIDTH);
  localparam int DLY_AW   = $clog2(DELAY_DEPTH);
  localparam int DLY_W    = $clog2(DELAY_DEPTH + 1);
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 11;

  // Default threshold after reset
  localparam logic [PIX_W-1:0] THRESHOLD_RST = PIX_W'(125);

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MARGIN       = 2'd2,
    CFG_THRESHOLD    = 2'd3
  } cfg_reg_e;

  // Channel payloads
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             is_padding;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;
  } out_item_t;

  // Geometry derived from the configuration registers
  typedef struct packed {
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [MARGIN_W-1:0] m;
    logic [DIM_W-1:0]    wp;
    logic [DIM_W-1:0]    hp;
    logic [DLY_W-1:0]    dlen;
  } geom_t;

  // Position of the item at the input
  typedef struct packed {
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
    logic             in_image;
    logic             has_result;
    logic             frame_start;
    logic             frame_last;
  } pos_t;

endpackage

>>> rtl/obstacle_margin_dilation_core.sv
// ----------------------------------------------------------------------------
// obstacle_margin_dilation_core
// Streaming square-window obstacle inflation of a grayscale map.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one result per clock once the stream is
// under way, unless out_ready holds the output; each item passes the input
// stage with the memory reads, then the window stage into the output register,
// and the rate is set by the single read-modify-write per cycle on the column
// counter memory. After reset a clearing pass sets all 1024 column counters to
// saturated, with in_ready low meanwhile. Each frame is sent as (frame_height +
// margin) rows of (frame_width + margin) items, padding items filling the extra
// positions; results start once margin rows and margin columns have gone by,
// and frame_last marks the last pixel of the frame. Configuration must be
// written only while no transfer is in flight; the core does not enforce it.
module obstacle_margin_dilation_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  omd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output omd_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [omd_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [omd_pkg::CFG_DW-1:0]    cfg_wdata
);
  import omd_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]    frame_width_r, frame_height_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [PIX_W-1:0]    threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_W'(MAX_WIDTH);
      frame_height_r <= DIM_W'(MAX_HEIGHT);
      margin_r       <= '0;
      threshold_r    <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_MARGIN:       margin_r       <= cfg_wdata[MARGIN_W-1:0];
        CFG_THRESHOLD:    threshold_r    <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  geom_t geom;
  pos_t  pos;
  logic  in_xfer;
  logic  clr_busy;

  omd_pos_track u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .margin       (margin_r),
    .advance      (in_xfer),
    .geom         (geom),
    .pos          (pos)
  );

  // Input stage decode
  logic             obst;
  logic [PIX_W-1:0] cur_pix;

  assign obst    = pos.in_image && !in_data.is_padding && (in_data.pixel < threshold_r);
  assign cur_pix = pos.in_image ? in_data.pixel : '0;

  // Window stage registers
  logic               s1_valid_r;
  pos_t               s1_pos_r;
  logic               s1_obst_r;
  logic [PIX_W-1:0]   s1_cur_r;
  logic               s1_fwd_r;
  logic [QUIET_W-1:0] s1_fwd_q_r;
  logic [QUIET_W-1:0] row_quiet_r, row_quiet_nxt;
  logic               s1_adv;
  logic               s1_col_we;

  logic               out_valid_r;
  out_item_t          out_data_r;

  // Handshake: the window stage moves unless its result is held at the output
  assign s1_adv   = s1_valid_r && (!s1_pos_r.has_result || !out_valid_r || out_ready);
  assign in_ready = !clr_busy && (!s1_valid_r || s1_adv);
  assign in_xfer  = in_valid && in_ready;

  // Column counter memory
  logic [QUIET_W-1:0] col_rd_q;
  logic [QUIET_W-1:0] col_q;

  omd_col_store u_col (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (pos.c[COL_AW-1:0]),
    .rd_data (col_rd_q),
    .wr_en   (s1_adv && s1_col_we),
    .wr_addr (s1_pos_r.c[COL_AW-1:0]),
    .wr_data (col_q),
    .busy    (clr_busy)
  );

  // Centre pixel delay ring
  logic [PIX_W-1:0] dly_pix;
  logic             s1_dzero_r;

  omd_delay_line u_dly (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_xfer),
    .frame_start (pos.frame_start),
    .dlen        (geom.dlen),
    .wr_pixel    (cur_pix),
    .rd_pixel    (dly_pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (in_xfer) s1_valid_r <= 1'b1;
    else if (s1_adv) s1_valid_r <= 1'b0;
  end

  // Payload of the window stage; forward a same-column update of the
  // previous item, which the memory read misses
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pos_r   <= pos;
      s1_obst_r  <= obst;
      s1_cur_r   <= cur_pix;
      s1_dzero_r <= (geom.dlen == '0);
      s1_fwd_r   <= s1_adv && s1_col_we && (s1_pos_r.c == pos.c);
      s1_fwd_q_r <= col_q;
    end
  end

  // Column and row quiet counts
  logic [QUIET_W-1:0] q_prev, row_base;
  logic [DIM_W-1:0]   win;
  logic               col_hit;
  logic [PIX_W-1:0]   centre;

  always_comb begin
    win       = DIM_W'({geom.m, 1'b0});
    s1_col_we = (s1_pos_r.c < geom.w);
    if (s1_pos_r.r == '0) q_prev = QUIET_W'(QUIET_SAT);
    else if (s1_fwd_r) q_prev = s1_fwd_q_r;
    else q_prev = col_rd_q;
    if (s1_obst_r) col_q = '0;
    else if (q_prev < QUIET_W'(QUIET_SAT)) col_q = q_prev + QUIET_W'(1);
    else col_q = q_prev;
    col_hit = s1_col_we && (DIM_W'(col_q) <= win);

    row_base = (s1_pos_r.c == '0) ? QUIET_W'(QUIET_SAT) : row_quiet_r;
    if (col_hit) row_quiet_nxt = '0;
    else if (row_base < QUIET_W'(QUIET_SAT)) row_quiet_nxt = row_base + QUIET_W'(1);
    else row_quiet_nxt = row_base;

    centre = s1_dzero_r ? s1_cur_r : dly_pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_quiet_r <= QUIET_W'(QUIET_SAT);
    else if (s1_adv) row_quiet_r <= row_quiet_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (s1_adv && s1_pos_r.has_result) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pos_r.has_result) begin
      out_data_r.out_pixel  <= (DIM_W'(row_quiet_nxt) <= win) ? '0 : centre;
      out_data_r.frame_last <= s1_pos_r.frame_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/omd_pos_track.sv
// ----------------------------------------------------------------------------
// omd_pos_track
// Derives the clamped frame geometry and tracks the padded raster position
// of the stream, advancing by one on every input transfer.
// ----------------------------------------------------------------------------
module omd_pos_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [omd_pkg::DIM_W-1:0]     frame_width,
  input  logic [omd_pkg::DIM_W-1:0]     frame_height,
  input  logic [omd_pkg::MARGIN_W-1:0]  margin,
  input  logic                          advance,
  output omd_pkg::geom_t                geom,
  output omd_pkg::pos_t                 pos
);
  import omd_pkg::*;

  logic [DIM_W-1:0]    w, h, wp, hp;
  logic [MARGIN_W-1:0] m;
  logic [DIM_W-1:0]    col_r, row_r, col_nxt, row_nxt;
  logic [DIM_W:0]      row_pre, row_inc;
  logic [DIM_W:0]      col_inc;
  logic [DIM_W-1:0]    r, c;

  // Clamp sizes and build the padded geometry
  always_comb begin
    if (frame_width == '0) w = DIM_W'(1);
    else if (frame_width > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
    else w = frame_width;
    if (frame_height == '0) h = DIM_W'(1);
    else if (frame_height > DIM_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
    else h = frame_height;
    if (margin > MARGIN_W'(MAX_MARGIN)) m = MARGIN_W'(MAX_MARGIN);
    else m = margin;
    wp = w + DIM_W'(m);
    hp = h + DIM_W'(m);
    geom.w    = w;
    geom.h    = h;
    geom.m    = m;
    geom.wp   = wp;
    geom.hp   = hp;
    geom.dlen = DLY_W'(m) * DLY_W'(wp) + DLY_W'(m);
  end

  // Wrap a position left out of range by a geometry change
  always_comb begin
    if (col_r >= wp) begin
      c       = '0;
      row_pre = {1'b0, row_r} + (DIM_W+1)'(1);
    end else begin
      c       = col_r;
      row_pre = {1'b0, row_r};
    end
    if (row_pre >= {1'b0, hp}) r = '0;
    else r = row_pre[DIM_W-1:0];

    pos.r           = r;
    pos.c           = c;
    pos.in_image    = (r < h) && (c < w);
    pos.has_result  = (r >= DIM_W'(m)) && (c >= DIM_W'(m));
    pos.frame_start = (r == '0) && (c == '0);
    pos.frame_last  = (r == hp - DIM_W'(1)) && (c == wp - DIM_W'(1));
  end

  // Step to the next padded position
  always_comb begin
    col_inc = {1'b0, c} + (DIM_W+1)'(1);
    row_inc = {1'b0, r} + (DIM_W+1)'(1);
    if (col_inc >= {1'b0, wp}) begin
      col_nxt = '0;
      if (row_inc >= {1'b0, hp}) row_nxt = '0;
      else row_nxt = row_inc[DIM_W-1:0];
    end else begin
      col_nxt = col_inc[DIM_W-1:0];
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> rtl/omd_col_store.sv
// ----------------------------------------------------------------------------
// omd_col_store
// Per-column quiet counters: one write and one registered read per cycle,
// with a clearing pass after reset that sets every entry to saturated.
// ----------------------------------------------------------------------------
module omd_col_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [omd_pkg::COL_AW-1:0]    rd_addr,
  output logic [omd_pkg::QUIET_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [omd_pkg::COL_AW-1:0]    wr_addr,
  input  logic [omd_pkg::QUIET_W-1:0]   wr_data,
  output logic                          busy
);
  import omd_pkg::*;

  logic [QUIET_W-1:0] mem [MAX_WIDTH];
  logic [QUIET_W-1:0] rd_data_r;
  logic [COL_AW:0]    clr_cnt_r;
  logic               we;
  logic [COL_AW-1:0]  wa;
  logic [QUIET_W-1:0] wd;

  assign busy = (clr_cnt_r != (COL_AW+1)'(MAX_WIDTH));

  // Clearing pass walks the columns once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (busy) clr_cnt_r <= clr_cnt_r + (COL_AW+1)'(1);
  end

  // Write port: clearing pass or counter update
  always_comb begin
    if (busy) begin
      we = 1'b1;
      wa = clr_cnt_r[COL_AW-1:0];
      wd = QUIET_W'(QUIET_SAT);
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/omd_delay_line.sv
// ----------------------------------------------------------------------------
// omd_delay_line
// Ring of centre pixels of length margin * (padded width) + margin. For a
// nonzero length each transfer reads the oldest entry and writes wr_pixel there.
// ----------------------------------------------------------------------------
module omd_delay_line (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        frame_start,
  input  logic [omd_pkg::DLY_W-1:0]   dlen,
  input  logic [omd_pkg::PIX_W-1:0]   wr_pixel,
  output logic [omd_pkg::PIX_W-1:0]   rd_pixel
);
  import omd_pkg::*;

  logic [PIX_W-1:0]  mem [DELAY_DEPTH];
  logic [PIX_W-1:0]  rd_pixel_r;
  logic [DLY_W-1:0]  ptr_r, ptr_nxt, ptr_cur, ptr_inc;
  logic              active;

  assign active = (dlen != '0);

  // Ring pointer, restarted at frame start and kept inside the ring
  always_comb begin
    ptr_cur = frame_start ? '0 : ptr_r;
    if (active && ptr_cur >= dlen) ptr_cur = '0;
    ptr_inc = ptr_cur + DLY_W'(1);
    if (!active) ptr_nxt = ptr_cur;
    else if (ptr_inc >= dlen) ptr_nxt = '0;
    else ptr_nxt = ptr_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ptr_r <= '0;
    else if (advance) ptr_r <= ptr_nxt;
  end

  // Read-first access at the same address
  always_ff @(posedge clk) begin
    if (advance && active) begin
      mem[ptr_cur[DLY_AW-1:0]] <= wr_pixel;
      rd_pixel_r               <= mem[ptr_cur[DLY_AW-1:0]];
    end
  end

  assign rd_pixel = rd_pixel_r;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for obstacle_margin_dilation_core.
// Frames of padded raster items are streamed in with random gaps on both
// channels. A predictor object follows every accepted transfer and queues the
// inflated pixel it expects. Each output transfer is checked against the
// oldest entry. A short hand-written set of frames comes first, then one
// very wide frame, then random geometry and content.
// ----------------------------------------------------------------------------
module tb;
  import omd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 250;
  localparam int MAX_REPORTS    = 10;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_we;
  logic [CFG_IW-1:0]  cfg_index;
  logic [CFG_DW-1:0]  cfg_wdata;

  bit idle_enable;

  // Predictor and store of expected inflated pixels
  class dilation_scoreboard;
    logic [DIM_W-1:0]    reg_width;
    logic [DIM_W-1:0]    reg_height;
    logic [MARGIN_W-1:0] reg_margin;
    logic [PIX_W-1:0]    reg_thr;
    logic [PIX_W-1:0]    centre_ring [DELAY_DEPTH];
    int                  col_quiet [MAX_WIDTH];
    int                  row_quiet;
    int                  pos_r;
    int                  pos_c;
    int                  ring_pos;
    out_item_t           inflated_q [$];
    int                  errors;

    function new();
      reg_width  = DIM_W'(1024);
      reg_height = DIM_W'(1024);
      reg_margin = '0;
      reg_thr    = THRESHOLD_RST;
      foreach (centre_ring[i]) centre_ring[i] = '0;
      foreach (col_quiet[i]) col_quiet[i] = QUIET_SAT;
      row_quiet = QUIET_SAT;
      pos_r     = 0;
      pos_c     = 0;
      ring_pos  = 0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DW-1:0] v);
      case (idx)
        CFG_FRAME_WIDTH:  reg_width  = v[DIM_W-1:0];
        CFG_FRAME_HEIGHT: reg_height = v[DIM_W-1:0];
        CFG_MARGIN:       reg_margin = v[MARGIN_W-1:0];
        CFG_THRESHOLD:    reg_thr    = v[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamped frame size and margin
    function void geometry(output int w, output int h, output int m);
      w = (reg_width == 0) ? 1 : (reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width);
      h = (reg_height == 0) ? 1 : (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height);
      m = (reg_margin > MAX_MARGIN) ? MAX_MARGIN : int'(reg_margin);
    endfunction

    function int pending();
      return inflated_q.size();
    endfunction

    // Advance the window state by one accepted item
    function void predict_inflated(in_item_t it);
      int        w, h, m, wp, hp, win, dlen, r, c, q, centre, cur;
      bit        in_image, obst, col_hit;
      out_item_t res;
      geometry(w, h, m);
      wp   = w + m;
      hp   = h + m;
      win  = 2 * m;
      dlen = m * wp + m;
      if (pos_c >= wp) begin
        pos_c = 0;
        pos_r++;
      end
      if (pos_r >= hp) pos_r = 0;
      r = pos_r;
      c = pos_c;

      in_image = (r < h) && (c < w);
      obst     = in_image && !it.is_padding && (it.pixel < reg_thr);

      // column counters restart on the first row of a frame
      col_hit = 1'b0;
      if (c < w) begin
        q = (r == 0) ? QUIET_SAT : col_quiet[c];
        if (obst) q = 0;
        else if (q < QUIET_SAT) q++;
        col_quiet[c] = q;
        col_hit = (q <= win);
      end

      if (c == 0) row_quiet = QUIET_SAT;
      if (col_hit) row_quiet = 0;
      else if (row_quiet < QUIET_SAT) row_quiet++;

      // centre pixel delay line
      if (r == 0 && c == 0) ring_pos = 0;
      cur = in_image ? int'(it.pixel) : 0;
      if (dlen == 0) begin
        centre = cur;
      end else begin
        if (ring_pos >= dlen) ring_pos = 0;
        centre = int'(centre_ring[ring_pos]);
        centre_ring[ring_pos] = PIX_W'(cur);
        ring_pos = (ring_pos + 1 >= dlen) ? 0 : ring_pos + 1;
      end

      if (r >= m && c >= m) begin
        res.out_pixel  = (row_quiet <= win) ? '0 : PIX_W'(centre);
        res.frame_last = (r == hp - 1) && (c == wp - 1);
        inflated_q = {inflated_q, res};
      end

      pos_c++;
      if (pos_c >= wp) begin
        pos_c = 0;
        pos_r++;
        if (pos_r >= hp) pos_r = 0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (inflated_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected result: pixel %0d last %0b", got.out_pixel, got.frame_last);
        errors++;
        return;
      end
      want = inflated_q.pop_front();
      if (got.out_pixel !== want.out_pixel || got.frame_last !== want.frame_last) begin
        if (errors < MAX_REPORTS)
          $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                   want.out_pixel, want.frame_last, got.out_pixel, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  dilation_scoreboard sb = new();

  obstacle_margin_dilation_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int sel;
    if (!idle_enable) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Ends the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input in_item_t it, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_inflated(it);
  endtask

  // Hold the sender off until every expected result is out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DW'(value);
    sb.set_reg(idx, CFG_DW'(value));
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Register writes; margin and threshold get junk in the unused upper bits
  task automatic configure(input int w, input int h, input int m, input int thr);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_MARGIN, ($urandom_range(0, 255) << MARGIN_W) | m);
    write_reg(CFG_THRESHOLD, ($urandom_range(0, 7) << PIX_W) | thr);
  endtask

  // One complete padded frame with random content
  task automatic send_frame(input int obst_pct, input int noise_pct, input bit pause_mid,
                            output int count);
    int       w, h, m, thr, idx;
    in_item_t it;
    sb.geometry(w, h, m);
    thr   = int'(sb.reg_thr);
    count = (w + m) * (h + m);
    idx   = 0;
    for (int r = 0; r < h + m; r++) begin
      for (int c = 0; c < w + m; c++) begin
        it.is_padding = !((r < h) && (c < w));
        if ($urandom_range(0, 99) < noise_pct) it.is_padding = ~it.is_padding;
        if (thr > 0 && $urandom_range(0, 99) < obst_pct)
          it.pixel = PIX_W'($urandom_range(0, thr - 1));
        else
          it.pixel = PIX_W'($urandom_range(thr, 255));
        if (pause_mid && idx == count / 2) drain();
        send_item(it, pick_gap());
        idx++;
      end
    end
  endtask

  initial begin : main
    int random_items, count, w, h, m, thr, sel, frames, obst_pct, noise_pct;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_FRAME_WIDTH;
    cfg_wdata   = '0;
    idle_enable = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x2 frame, margin and threshold left at their reset values:
    // threshold boundary, extremes, padding flag on an image pixel
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 2);
    send_item(in_item_t'{8'd124, 1'b0}, 0);
    send_item(in_item_t'{8'd125, 1'b0}, 0);
    send_item(in_item_t'{8'd0,   1'b0}, 0);
    send_item(in_item_t'{8'd255, 1'b0}, 0);
    send_item(in_item_t'{8'd50,  1'b1}, 0);
    send_item(in_item_t'{8'd200, 1'b0}, 0);
    drain();

    // zero sizes clamp to a single pixel; top threshold
    configure(0, 0, 0, 255);
    send_item(in_item_t'{8'd255, 1'b0}, 0);
    send_item(in_item_t'{8'd254, 1'b0}, 1);
    drain();

    // 2x2 with margin 1: obstacle spreads, pixels at padding positions
    configure(2, 2, 1, 128);
    send_item(in_item_t'{8'd255, 1'b0}, 0);
    send_item(in_item_t'{8'd10,  1'b0}, 0);
    send_item(in_item_t'{8'd0,   1'b0}, 0);
    send_item(in_item_t'{8'd200, 1'b0}, 0);
    send_item(in_item_t'{8'd77,  1'b1}, 0);
    send_item(in_item_t'{8'd0,   1'b1}, 0);
    send_item(in_item_t'{8'd0,   1'b0}, 0);
    send_item(in_item_t'{8'd0,   1'b0}, 0);
    send_item(in_item_t'{8'd99,  1'b1}, 0);
    drain();

    // widest row clamped to the maximum, single row
    idle_enable = 1'b1;
    configure(2047, 1, 0, $urandom_range(1, 254));
    send_frame(3, 5, 1'b1, count);
    drain();

    // random geometry, threshold and content
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      w = (sel < 8) ? 0 : (sel < 16) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      sel = $urandom_range(0, 99);
      h = (sel < 8) ? 0 : $urandom_range(1, 8);
      sel = $urandom_range(0, 99);
      m = (sel < 15) ? 0 : (sel < 30) ? MAX_MARGIN : $urandom_range(1, MAX_MARGIN - 1);
      sel = $urandom_range(0, 99);
      thr = (sel < 15) ? 0 : (sel < 30) ? 255 : $urandom_range(1, 254);
      configure(w, h, m, thr);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        case ($urandom_range(0, 3))
          0: obst_pct = 0;
          1: obst_pct = 3;
          2: obst_pct = 15;
          default: obst_pct = 50;
        endcase
        noise_pct = $urandom_range(0, 10);
        send_frame(obst_pct, noise_pct, ($urandom_range(0, 3) == 0), count);
        random_items += count;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
